// ===== rtl/sgrs_pkg.sv =====
// Shared types, character codes and control structs for the SGR escape stripper.
package sgrs_pkg;

    // Default depth of the store that holds a pending sequence.
    localparam int MAX_PENDING_DEF = 32;

    // Characters that the parser looks for.
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_M        = 8'h6d;
    localparam logic [7:0] CH_SEMI     = 8'h3b;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;

    // Input item: a data byte or a flush command.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    // Output item: one byte of the filtered stream.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // Source of the byte loaded into the output register.
    typedef enum logic [1:0] {
        SEL_INPUT = 2'd0,
        SEL_MEM   = 2'd1,
        SEL_TAIL  = 2'd2
    } t_out_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     hold_wr;
        logic     cnt_clr;
        logic     idx_inc;
        logic     rp_start;
        logic     rp_tail;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_esc;
        logic is_lbr;
        logic is_m;
        logic is_param;
        logic cnt_zero;
        logic cnt_full;
        logic at_end;
        logic tail_en;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/ansi_sgr_escape_stripper.sv =====
// Top level of the ANSI SGR escape sequence stripper.
//
//   channel  direction  handshake                    payload
//   input    in         i_in_valid / o_in_stall      i_in_item  (cmd, data_byte)
//   output   out        o_out_valid / i_out_stall    o_out_item (out_byte, last)
//
// A byte either passes through to the output or is held; a complete sequence is dropped.
// A replay reads each held byte in turn from the registered read port of the pending store
// (a read state, then an emit state), then emits the breaking byte (none on a flush).
// Reset sets the parser idle, the held count to zero and the output empty; the store is not
// cleared. A stall on the output holds the output register and stalls input once it is full.
module ansi_sgr_escape_stripper
    import sgrs_pkg::*;
#(
    parameter int MAX_PENDING = MAX_PENDING_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Parse and replay sequencing.
    sgrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flush    (i_in_item.cmd),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Pending store and output register.
    sgrs_datapath #(
        .MAX_PENDING (MAX_PENDING)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in_item.data_byte),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/sgrs_datapath.sv =====
// Datapath: pending byte store, counters, replay tail byte and output register.
module sgrs_datapath
    import sgrs_pkg::*;
#(
    parameter int MAX_PENDING = MAX_PENDING_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_data_byte,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);

    localparam int CW = $clog2(MAX_PENDING + 1);
    localparam int AW = $clog2(MAX_PENDING);

    logic [7:0]    r_mem [MAX_PENDING];
    logic [7:0]    r_rdata;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [7:0]    r_tail;
    logic          r_tail_en;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out;
    logic [7:0]    out_src;

    // Store write at the fill position and registered read at the replay index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_wr) begin
            r_mem[r_count[AW-1:0]] <= i_data_byte;
        end
        r_rdata <= r_mem[r_idx];
    end

    // Fill count and replay index.
    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_clr) begin
            n_count = '0;
        end else if (i_cmd.hold_wr) begin
            n_count = r_count + CW'(1);
        end
        n_idx = r_idx;
        if (i_cmd.rp_start) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // Byte that follows the replayed bytes, if any.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_en <= 1'b0;
        end else if (i_cmd.rp_start) begin
            r_tail_en <= i_cmd.rp_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rp_start) begin
            r_tail <= i_data_byte;
        end
    end

    // Output register; it frees up when the current item transfers.
    always_comb begin
        unique case (i_cmd.out_sel)
            SEL_INPUT: out_src = i_data_byte;
            SEL_MEM:   out_src = r_rdata;
            SEL_TAIL:  out_src = r_tail;
            default:   out_src = i_data_byte;
        endcase
        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_byte <= out_src;
            r_out.last     <= i_cmd.out_last;
        end
    end

    // Status for the controller.
    always_comb begin
        o_status.is_esc   = (i_data_byte == CH_ESC);
        o_status.is_lbr   = (i_data_byte == CH_LBRACKET);
        o_status.is_m     = (i_data_byte == CH_M);
        o_status.is_param = ((i_data_byte >= CH_DIGIT_0) && (i_data_byte <= CH_DIGIT_9))
                            || (i_data_byte == CH_SEMI);
        o_status.cnt_zero = (r_count == '0);
        o_status.cnt_full = (r_count == CW'(MAX_PENDING));
        o_status.at_end   = (CW'(r_idx) == (r_count - CW'(1)));
        o_status.tail_en  = r_tail_en;
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The fill count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PENDING))
        else $error("held byte count exceeds store depth");

    // A byte is only stored while there is room for it.
    a_hold_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hold_wr |-> !o_status.cnt_full)
        else $error("write into a full pending store");

    // A new output never overwrites one that is still waiting.
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_status.out_free)
        else $error("output register loaded while stalled");

endmodule

// ===== rtl/sgrs_ctrl.sv =====
// Controller: parse state machine that sequences holds, drops and replays.
module sgrs_ctrl
    import sgrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_flush,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ESC   = 6'b000010,
        ST_PARAM = 6'b000100,
        ST_READ  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_TAIL  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   parsing;
    logic   acc;

    // Items are taken only in the parse states and with room at the output.
    assign parsing    = (r_state == ST_IDLE) || (r_state == ST_ESC) || (r_state == ST_PARAM);
    assign o_in_stall = !parsing || !i_status.out_free;
    assign acc        = i_in_valid && !o_in_stall;

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        o_cmd.hold_wr  = 1'b0;
        o_cmd.cnt_clr  = 1'b0;
        o_cmd.idx_inc  = 1'b0;
        o_cmd.rp_start = 1'b0;
        o_cmd.rp_tail  = 1'b0;
        o_cmd.out_load = 1'b0;
        o_cmd.out_sel  = SEL_INPUT;
        o_cmd.out_last = 1'b0;
        unique case (r_state)
            ST_IDLE, ST_ESC, ST_PARAM: begin
                if (acc) begin
                    priority if (i_flush) begin
                        // A flush replays whatever is held, without a tail byte.
                        o_cmd.rp_start = 1'b1;
                        n_state        = i_status.cnt_zero ? ST_IDLE : ST_READ;
                    end else if (r_state == ST_IDLE) begin
                        if (i_status.is_esc) begin
                            o_cmd.hold_wr = 1'b1;
                            n_state       = ST_ESC;
                        end else begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                        end
                    end else if (r_state == ST_ESC) begin
                        if (i_status.is_lbr) begin
                            o_cmd.hold_wr = 1'b1;
                            n_state       = ST_PARAM;
                        end else begin
                            o_cmd.rp_start = 1'b1;
                            o_cmd.rp_tail  = 1'b1;
                            n_state        = ST_READ;
                        end
                    end else begin
                        priority if (i_status.is_m) begin
                            // Complete sequence: drop everything held.
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = ST_IDLE;
                        end else if (i_status.is_param && !i_status.cnt_full) begin
                            o_cmd.hold_wr = 1'b1;
                        end else begin
                            o_cmd.rp_start = 1'b1;
                            o_cmd.rp_tail  = 1'b1;
                            n_state        = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                // The store read issued here is valid in the next cycle.
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = SEL_MEM;
                    o_cmd.out_last = i_status.at_end && !i_status.tail_en;
                    if (i_status.at_end) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = i_status.tail_en ? ST_TAIL : ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
            ST_TAIL: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = SEL_TAIL;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
